// ----- rtl/ast_pkg.sv -----
// Shared types and constants for the allocation slot tracker.
// No dependencies.
`timescale 1ns / 1ps

package ast_pkg;

  localparam int OP_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_RECORD  = 2'd0,
    OP_UPDATE  = 2'd1,
    OP_RELEASE = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_CLEAR,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/ast_slot_mem.sv -----
// Slot address store: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ast_slot_mem #(
  parameter int SLOT_COUNT = 1024,
  parameter int ADDR_WIDTH = 32,
  parameter int IW         = 10
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [IW-1:0]         waddr,
  input  logic [ADDR_WIDTH-1:0] wdata,
  input  logic                  re,
  input  logic [IW-1:0]         raddr,
  output logic [ADDR_WIDTH-1:0] rdata
);

  logic [ADDR_WIDTH-1:0] mem [SLOT_COUNT];
  logic [ADDR_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/ast_bounds.sv -----
// Address bounds and high-water count, with the span derived from them.
// No dependencies.
`timescale 1ns / 1ps

module ast_bounds #(
  parameter int ADDR_WIDTH = 32,
  parameter int IW         = 10,
  parameter int HW         = 11
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  upd,
  input  logic [IW-1:0]         idx,
  input  logic [ADDR_WIDTH-1:0] addr,
  input  logic [ADDR_WIDTH-1:0] size,
  output logic [HW-1:0]         high_water,
  output logic [ADDR_WIDTH:0]   span
);

  logic [ADDR_WIDTH-1:0] lowest_r, lowest_nxt;
  logic [ADDR_WIDTH:0]   highest_r, highest_nxt;
  logic [HW-1:0]         hw_r, hw_nxt;
  logic [ADDR_WIDTH:0]   end_addr;
  logic [HW-1:0]         idx_ext;

  always_comb begin
    end_addr    = {1'b0, addr} + {1'b0, size};
    idx_ext     = HW'(idx);
    lowest_nxt  = lowest_r;
    highest_nxt = highest_r;
    hw_nxt      = hw_r;
    if (upd) begin
      if (hw_r <= idx_ext) begin
        hw_nxt = idx_ext + HW'(1);
      end
      if (lowest_r > addr) begin
        lowest_nxt = addr;
      end
      if (highest_r < end_addr) begin
        highest_nxt = end_addr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lowest_r  <= '1;
      highest_r <= '0;
      hw_r      <= '0;
    end else begin
      lowest_r  <= lowest_nxt;
      highest_r <= highest_nxt;
      hw_r      <= hw_nxt;
    end
  end

  assign high_water = hw_r;
  assign span = (highest_r > {1'b0, lowest_r}) ? (highest_r - {1'b0, lowest_r}) : '0;

endmodule

// ----- rtl/ast_ctrl.sv -----
// Sequencer: slot scan, clear and reset sweeps, result register.
// Depends on ast_pkg; drives ast_slot_mem and ast_bounds.
`timescale 1ns / 1ps

module ast_ctrl #(
  parameter int SLOT_COUNT = 1024,
  parameter int ADDR_WIDTH = 32,
  parameter int IW         = 10,
  parameter int HW         = 11,
  parameter int IN_W       = 96,
  parameter int OUT_W      = 56
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [IN_W-1:0]            in_tdata,
  input  logic [ast_pkg::OP_W-1:0]   in_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [OUT_W-1:0]           out_tdata,
  output logic                       mem_we,
  output logic [IW-1:0]              mem_waddr,
  output logic [ADDR_WIDTH-1:0]      mem_wdata,
  output logic                       mem_re,
  output logic [IW-1:0]              mem_raddr,
  input  logic [ADDR_WIDTH-1:0]      mem_rdata,
  output logic                       bnd_upd,
  output logic [IW-1:0]              bnd_idx,
  output logic [ADDR_WIDTH-1:0]      bnd_addr,
  output logic [ADDR_WIDTH-1:0]      bnd_size,
  input  logic [HW-1:0]              bnd_high_water,
  input  logic [ADDR_WIDTH:0]        bnd_span
);

  localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

  ast_pkg::state_t       state_r, state_nxt;
  logic [IW-1:0]         iss_r, iss_nxt;
  logic                  chk_vld_r, chk_vld_nxt;
  logic [IW-1:0]         chk_idx_r, chk_idx_nxt;
  logic                  out_vld_r, out_vld_nxt;
  logic [OUT_W-1:0]      out_data_r, out_data_nxt;
  ast_pkg::op_t          op_r, op_nxt;
  logic [ADDR_WIDTH-1:0] addr_r, addr_nxt;
  logic [ADDR_WIDTH-1:0] new_r, new_nxt;
  logic [ADDR_WIDTH-1:0] size_r, size_nxt;
  logic                  hit_r, hit_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic [ADDR_WIDTH-1:0] key;
  logic                  match;
  logic                  zsize;
  logic                  in_xfer;
  logic                  iss_last;

  always_comb begin
    in_xfer  = in_tvalid && in_tready;
    iss_last = (iss_r == LAST_IDX);
    key      = (op_r == ast_pkg::OP_RECORD) ? '0 : addr_r;
    match    = (state_r == ast_pkg::ST_SCAN) && chk_vld_r && (mem_rdata == key);
    zsize    = ((op_r == ast_pkg::OP_RECORD) || (op_r == ast_pkg::OP_UPDATE)) &&
               (size_r == '0);
  end

  always_comb begin
    state_nxt    = state_r;
    iss_nxt      = iss_r;
    chk_vld_nxt  = chk_vld_r;
    chk_idx_nxt  = chk_idx_r;
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    op_nxt       = op_r;
    addr_nxt     = addr_r;
    new_nxt      = new_r;
    size_nxt     = size_r;
    hit_nxt      = hit_r;
    idx_nxt      = idx_r;
    in_tready    = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = iss_r;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = iss_r;
    bnd_upd      = 1'b0;

    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      ast_pkg::ST_INIT: begin
        mem_we  = 1'b1;
        iss_nxt = iss_last ? '0 : iss_r + IW'(1);
        if (iss_last) begin
          state_nxt = ast_pkg::ST_IDLE;
        end
      end
      ast_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_xfer) begin
          op_nxt      = ast_pkg::op_t'(in_tuser);
          addr_nxt    = in_tdata[ADDR_WIDTH-1:0];
          new_nxt     = in_tdata[2*ADDR_WIDTH-1:ADDR_WIDTH];
          size_nxt    = in_tdata[3*ADDR_WIDTH-1:2*ADDR_WIDTH];
          iss_nxt     = '0;
          chk_vld_nxt = 1'b0;
          hit_nxt     = 1'b0;
          idx_nxt     = '0;
          state_nxt   = (ast_pkg::op_t'(in_tuser) == ast_pkg::OP_CLEAR) ?
                        ast_pkg::ST_CLEAR : ast_pkg::ST_SCAN;
        end
      end
      ast_pkg::ST_SCAN: begin
        mem_re      = 1'b1;
        iss_nxt     = iss_last ? '0 : iss_r + IW'(1);
        chk_vld_nxt = 1'b1;
        chk_idx_nxt = iss_r;
        if (match) begin
          mem_we    = 1'b1;
          mem_waddr = chk_idx_r;
          case (op_r)
            ast_pkg::OP_RECORD: mem_wdata = addr_r;
            ast_pkg::OP_UPDATE: mem_wdata = new_r;
            default:            mem_wdata = '0;
          endcase
          bnd_upd   = (op_r == ast_pkg::OP_RECORD);
          hit_nxt   = 1'b1;
          idx_nxt   = chk_idx_r;
          state_nxt = ast_pkg::ST_DONE;
        end else if (chk_vld_r && (chk_idx_r == LAST_IDX)) begin
          state_nxt = ast_pkg::ST_DONE;
        end
      end
      ast_pkg::ST_CLEAR: begin
        mem_we  = 1'b1;
        iss_nxt = iss_last ? '0 : iss_r + IW'(1);
        if (iss_last) begin
          state_nxt = ast_pkg::ST_DONE;
        end
      end
      ast_pkg::ST_DONE: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = OUT_W'({bnd_span, bnd_high_water, zsize, hit_r, idx_r});
          state_nxt    = ast_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ast_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ast_pkg::ST_INIT;
      iss_r     <= '0;
      chk_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      iss_r     <= iss_nxt;
      chk_vld_r <= chk_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r  <= chk_idx_nxt;
    out_data_r <= out_data_nxt;
    op_r       <= op_nxt;
    addr_r     <= addr_nxt;
    new_r      <= new_nxt;
    size_r     <= size_nxt;
    hit_r      <= hit_nxt;
    idx_r      <= idx_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign bnd_idx    = chk_idx_r;
  assign bnd_addr   = addr_r;
  assign bnd_size   = size_r;

endmodule

// ----- rtl/allocation_slot_tracker_top.sv -----
// Allocation slot tracker top: one item at a time. Record, update and release scan the
// store one slot per cycle from slot 0 until the first match or the last slot, then
// report; clear zeroes every slot in turn before it reports.
// in_tready rises with out_tvalid, so a new item is taken only after the last result is
// issued; a result held by out_tready stalls the next item. After reset a sweep zeroes
// the store before in_tready rises; bounds and high water take reset values.
// Depends on ast_pkg, ast_slot_mem, ast_bounds, ast_ctrl.
`timescale 1ns / 1ps

module allocation_slot_tracker_top #(
  parameter int SLOT_COUNT = 1024,
  parameter int ADDR_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // addr, repl_addr, block_size
  input  logic [((3*ADDR_WIDTH+7)/8)*8-1:0] in_tdata,
  // op
  input  logic [ast_pkg::OP_W-1:0] in_tuser,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // slot_index, hit, zero_size, slots_high_water, address_span
  output logic [(($clog2(SLOT_COUNT)+$clog2(SLOT_COUNT+1)+ADDR_WIDTH+3+7)/8)*8-1:0] out_tdata
);

  localparam int IW    = $clog2(SLOT_COUNT);
  localparam int HW    = $clog2(SLOT_COUNT + 1);
  localparam int IN_W  = ((3*ADDR_WIDTH + 7) / 8) * 8;
  localparam int OUT_W = ((IW + HW + ADDR_WIDTH + 3 + 7) / 8) * 8;

  logic                  mem_we;
  logic [IW-1:0]         mem_waddr;
  logic [ADDR_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [IW-1:0]         mem_raddr;
  logic [ADDR_WIDTH-1:0] mem_rdata;
  logic                  bnd_upd;
  logic [IW-1:0]         bnd_idx;
  logic [ADDR_WIDTH-1:0] bnd_addr;
  logic [ADDR_WIDTH-1:0] bnd_size;
  logic [HW-1:0]         bnd_high_water;
  logic [ADDR_WIDTH:0]   bnd_span;

  ast_slot_mem #(
    .SLOT_COUNT (SLOT_COUNT),
    .ADDR_WIDTH (ADDR_WIDTH),
    .IW         (IW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ast_bounds #(
    .ADDR_WIDTH (ADDR_WIDTH),
    .IW         (IW),
    .HW         (HW)
  ) u_bounds (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd        (bnd_upd),
    .idx        (bnd_idx),
    .addr       (bnd_addr),
    .size       (bnd_size),
    .high_water (bnd_high_water),
    .span       (bnd_span)
  );

  ast_ctrl #(
    .SLOT_COUNT (SLOT_COUNT),
    .ADDR_WIDTH (ADDR_WIDTH),
    .IW         (IW),
    .HW         (HW),
    .IN_W       (IN_W),
    .OUT_W      (OUT_W)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_re         (mem_re),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata),
    .bnd_upd        (bnd_upd),
    .bnd_idx        (bnd_idx),
    .bnd_addr       (bnd_addr),
    .bnd_size       (bnd_size),
    .bnd_high_water (bnd_high_water),
    .bnd_span       (bnd_span)
  );

endmodule

// ----- tb/ast_slot_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the allocation slot tracker: watches the input and result streams,
// keeps its own slot table, bounds and high-water count, and compares every result.
// Depends on ast_pkg.

module ast_slot_checker #(
  parameter int SLOT_COUNT = 1024,
  parameter int ADDR_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  input  logic                     in_tready,
  // addr, repl_addr, block_size
  input  logic [((3*ADDR_WIDTH+7)/8)*8-1:0] in_tdata,
  // op
  input  logic [ast_pkg::OP_W-1:0] in_tuser,
  input  logic                     out_tvalid,
  input  logic                     out_tready,
  // slot_index, hit, zero_size, slots_high_water, address_span
  input  logic [(($clog2(SLOT_COUNT)+$clog2(SLOT_COUNT+1)+ADDR_WIDTH+3+7)/8)*8-1:0] out_tdata,
  output int                       mismatches,
  output int                       reports_pending
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int HW_W  = $clog2(SLOT_COUNT + 1);
  localparam int AW    = ADDR_WIDTH;

  typedef struct packed {
    logic [AW:0]       span;
    logic [HW_W-1:0]   high_water;
    logic              zero_size;
    logic              hit;
    logic [IDX_W-1:0]  slot_index;
  } slot_report_t;

  logic [AW-1:0]   slot_addr [SLOT_COUNT];
  logic [AW-1:0]   lowest_start;
  logic [AW:0]     highest_end;
  logic [HW_W-1:0] high_water;
  slot_report_t    pending_reports [$];
  int              fail_total;

  function automatic int first_slot_holding(logic [AW-1:0] key);
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (slot_addr[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic slot_report_t track_item(ast_pkg::op_t op, logic [AW-1:0] addr,
                                              logic [AW-1:0] repl_addr,
                                              logic [AW-1:0] size);
    slot_report_t r;
    int           slot;
    logic [AW:0]  blk_end;
    r = '0;
    slot = -1;
    case (op)
      ast_pkg::OP_RECORD: begin
        r.zero_size = (size == '0);
        slot = first_slot_holding('0);
        if (slot >= 0) begin
          blk_end = {1'b0, addr} + {1'b0, size};
          if (high_water <= slot) high_water = HW_W'(slot + 1);
          if (lowest_start > addr) lowest_start = addr;
          if (highest_end < blk_end) highest_end = blk_end;
          slot_addr[slot] = addr;
        end
      end
      ast_pkg::OP_UPDATE: begin
        r.zero_size = (size == '0);
        slot = first_slot_holding(addr);
        if (slot >= 0) slot_addr[slot] = repl_addr;
      end
      ast_pkg::OP_RELEASE: begin
        slot = first_slot_holding(addr);
        if (slot >= 0) slot_addr[slot] = '0;
      end
      ast_pkg::OP_CLEAR: begin
        for (int i = 0; i < SLOT_COUNT; i++) slot_addr[i] = '0;
      end
      default: begin
      end
    endcase
    if (slot >= 0) begin
      r.hit = 1'b1;
      r.slot_index = IDX_W'(slot);
    end
    r.high_water = high_water;
    if (highest_end > {1'b0, lowest_start}) r.span = highest_end - {1'b0, lowest_start};
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      if (fail_total < 40)
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      fail_total++;
    end
  endtask

  always @(posedge clk) begin : watch
    slot_report_t seen;
    slot_report_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) slot_addr[i] = '0;
      lowest_start = '1;
      highest_end = '0;
      high_water = '0;
      pending_reports.delete();
      fail_total = 0;
    end else begin
      if (in_tvalid && in_tready)
        pending_reports.push_back(track_item(ast_pkg::op_t'(in_tuser), in_tdata[AW-1:0],
                                             in_tdata[2*AW-1:AW], in_tdata[3*AW-1:2*AW]));
      if (out_tvalid && out_tready) begin
        seen = slot_report_t'(out_tdata[$bits(slot_report_t)-1:0]);
        if (pending_reports.size() == 0) begin
          if (fail_total < 40)
            $display("%0t ns: result transfer with nothing outstanding, actual 0x%0h",
                     $time, out_tdata);
          fail_total++;
        end else begin
          want = pending_reports.pop_front();
          check_field("slot_index", want.slot_index, seen.slot_index);
          check_field("hit", want.hit, seen.hit);
          check_field("zero_size", want.zero_size, seen.zero_size);
          check_field("slots_high_water", want.high_water, seen.high_water);
          check_field("address_span", want.span, seen.span);
        end
      end
    end
    mismatches <= fail_total;
    reports_pending <= pending_reports.size();
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Top of the allocation slot tracker bench: clock, reset, stream stimulus and verdict.
// Depends on ast_pkg, allocation_slot_tracker_top and ast_slot_checker.

module tb;

  localparam int SLOT_COUNT     = 1024;
  localparam int AW             = 32;
  localparam int IN_W           = ((3*AW+7)/8)*8;
  localparam int OUT_W          = (($clog2(SLOT_COUNT)+$clog2(SLOT_COUNT+1)+AW+3+7)/8)*8;
  localparam int FILL_ITEMS     = 150;
  localparam int RANDOM_ITEMS   = 405;
  localparam int RX_HOLD_CYCLES = 400;

  logic                     clk;
  logic                     rst_n;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [IN_W-1:0]          in_tdata;
  logic [ast_pkg::OP_W-1:0] in_tuser;
  logic                     out_tvalid;
  logic                     out_tready;
  logic [OUT_W-1:0]         out_tdata;
  int                       mismatches;
  int                       reports_pending;
  int                       hold_requests = 0;
  int                       holds_done = 0;
  int                       op_count [4] = '{0, 0, 0, 0};
  logic [AW-1:0]            live_addrs [$];

  allocation_slot_tracker_top #(
    .SLOT_COUNT(SLOT_COUNT),
    .ADDR_WIDTH(AW)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  ast_slot_checker #(
    .SLOT_COUNT(SLOT_COUNT),
    .ADDR_WIDTH(AW)
  ) slot_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .mismatches      (mismatches),
    .reports_pending (reports_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(150_000_000);
    $display("[allocation_slot_tracker_top] ERROR");
    $finish;
  end

  // mostly short gaps, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [AW-1:0] rand_word();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom;
    if (r == 7) return '1;
    if (r == 8) return $urandom_range(0, 255);
    return '0;
  endfunction

  task automatic send_item(ast_pkg::op_t op, logic [AW-1:0] addr, logic [AW-1:0] repl_addr,
                           logic [AW-1:0] size);
    if ($urandom_range(0, 2) == 0) begin
      in_tvalid <= 1'b0;
      repeat (idle_len()) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= IN_W'({size, repl_addr, addr});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    op_count[op]++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (reports_pending != 0) @(posedge clk);
  endtask

  initial begin : receiver
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_requests != holds_done) begin
        out_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
        if ($urandom_range(0, 3) != 0) begin
          out_tready <= 1'b0;
          repeat (idle_len()) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    logic [AW-1:0] a;
    logic [AW-1:0] nw;
    logic [AW-1:0] probe;
    int            pick;
    int            k;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= ast_pkg::OP_RECORD;
    probe = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, address zero, zero size, misses, clear
    send_item(ast_pkg::OP_RECORD,  32'h0000_1000, 32'h0, 32'h0000_0100);
    send_item(ast_pkg::OP_RECORD,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(ast_pkg::OP_RECORD,  32'h0, 32'h0, 32'h0);
    send_item(ast_pkg::OP_RECORD,  32'h0000_0020, 32'h0, 32'h5);
    send_item(ast_pkg::OP_UPDATE,  32'h0000_1000, 32'h0000_2000, 32'h0);
    send_item(ast_pkg::OP_UPDATE,  32'h0, 32'hABCD_0000, 32'h7);
    send_item(ast_pkg::OP_UPDATE,  32'h1234_5678, 32'h1, 32'h1);
    send_item(ast_pkg::OP_RELEASE, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_item(ast_pkg::OP_RELEASE, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(ast_pkg::OP_RELEASE, 32'h5555_AAAA, 32'h0, 32'h0);
    send_item(ast_pkg::OP_RECORD,  32'h0000_0040, 32'h0, 32'h1);
    send_item(ast_pkg::OP_UPDATE,  32'hABCD_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(ast_pkg::OP_CLEAR,   $urandom, $urandom, $urandom);
    send_item(ast_pkg::OP_RELEASE, 32'h0000_0040, 32'h0, 32'h0);
    send_item(ast_pkg::OP_RECORD,  32'h8000_0000, 32'h0, 32'h7FFF_FFFF);
    send_item(ast_pkg::OP_UPDATE,  32'h8000_0000, 32'h0, 32'h10);
    send_item(ast_pkg::OP_RECORD,  32'h7FFF_FFFF, 32'h0, 32'h8000_0001);
    send_item(ast_pkg::OP_RELEASE, 32'h7FFF_FFFF, 32'h0, 32'h0);
    send_item(ast_pkg::OP_CLEAR,   32'h0, 32'h0, 32'h0);
    drain();

    // fill the low slots, then free and refill a slot in the middle
    send_item(ast_pkg::OP_CLEAR, $urandom, $urandom, $urandom);
    for (int i = 0; i < FILL_ITEMS; i++) begin
      a = $urandom;
      if (a == '0) a = 32'h1;
      if (i == FILL_ITEMS / 2) probe = a;
      send_item(ast_pkg::OP_RECORD, a, $urandom, rand_word());
    end
    send_item(ast_pkg::OP_UPDATE,  32'h0, 32'h0000_0100, 32'h10);
    send_item(ast_pkg::OP_RELEASE, probe, 32'h0, 32'h0);
    send_item(ast_pkg::OP_RECORD,  ~probe, 32'h0, 32'h0);
    send_item(ast_pkg::OP_RECORD,  probe, 32'h0, 32'h1);
    send_item(ast_pkg::OP_CLEAR,   32'h0, 32'h0, 32'h0);
    drain();

    // random: mostly record/update/release of live addresses, some noise
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 150) hold_requests++;
      if (n == 300) drain();
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_item(ast_pkg::OP_CLEAR, rand_word(), rand_word(), rand_word());
        live_addrs.delete();
      end else if (pick < 10) begin
        send_item(ast_pkg::op_t'($urandom_range(0, 2)), rand_word(), rand_word(),
                  rand_word());
      end else if ((pick < 45 && live_addrs.size() < 48) || live_addrs.size() == 0) begin
        a = rand_word();
        send_item(ast_pkg::OP_RECORD, a, rand_word(), rand_word());
        if (a != '0) live_addrs.push_back(a);
      end else begin
        k = $urandom_range(0, live_addrs.size() - 1);
        a = live_addrs[k];
        if (pick < 70) begin
          nw = rand_word();
          send_item(ast_pkg::OP_UPDATE, a, nw, rand_word());
          if (nw != '0) live_addrs[k] = nw;
          else live_addrs.delete(k);
        end else begin
          send_item(ast_pkg::OP_RELEASE, a, rand_word(), rand_word());
          live_addrs.delete(k);
        end
      end
    end

    drain();
    repeat (SLOT_COUNT + 8) @(posedge clk);
    $display("Run covered %0d record, %0d update, %0d release and %0d clear transfers,",
             op_count[ast_pkg::OP_RECORD], op_count[ast_pkg::OP_UPDATE],
             op_count[ast_pkg::OP_RELEASE], op_count[ast_pkg::OP_CLEAR]);
    $display("including a %0d-slot fill with a hole refilled; %0d field mismatches seen.",
             FILL_ITEMS, mismatches);
    if (mismatches == 0 && reports_pending == 0) begin
      $display("[allocation_slot_tracker_top] OK");
    end else begin
      $display("[allocation_slot_tracker_top] ERROR");
    end
    $finish;
  end

endmodule
